// ===== rtl/tfs_pkg.sv =====
// shared types and constants of the timed frame sequencer
package tfs_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SLOT_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CmdWrite   = 2'd0,
    CmdTick    = 2'd1,
    CmdRestart = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KindFrame = 2'd0,
    KindJump  = 2'd1,
    KindEnd   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [TIME_W-1:0]  duration;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  entry_index;
    logic [KIND_W-1:0]  entry_kind;
    logic [VALUE_W-1:0] entry_value;
    logic [TIME_W-1:0]  entry_duration;
    logic [TIME_W-1:0]  elapsed;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] display_frame;
    logic [SLOT_W-1:0]  position;
    logic               done_res;
    logic               jump_error;
  } result_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } table_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] show_idx;
    logic [IDX_W-1:0] next_idx;
    logic [IDX_W-1:0] tgt_idx;
  } table_rd_t;

endpackage

// ===== rtl/tfs_step_table.sv =====
// step table register file: one write port, indexed reads for the sequencer
module tfs_step_table (
  input  logic                clk_i,
  input  tfs_pkg::table_wr_t  wr_i,
  input  tfs_pkg::table_rd_t  rd_i,
  output tfs_pkg::entry_t     show_entry_o,
  output tfs_pkg::entry_t     next_entry_o,
  output tfs_pkg::entry_t     tgt_entry_o,
  output tfs_pkg::entry_t     zero_entry_o
);

  tfs_pkg::entry_t mem_q [tfs_pkg::TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.entry;
    end
  end

  assign show_entry_o = mem_q[rd_i.show_idx];
  assign next_entry_o = mem_q[rd_i.next_idx];
  assign tgt_entry_o  = mem_q[rd_i.tgt_idx];
  assign zero_entry_o = mem_q[0];

endmodule

// ===== rtl/tfs_seq_ctrl.sv =====
// sequencer state and the next-state logic for one item
module tfs_seq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tfs_pkg::item_t      item_i,
  output tfs_pkg::result_t    res_o
);

  localparam int unsigned NextW = tfs_pkg::IDX_W + 1;

  logic [tfs_pkg::IDX_W-1:0]  pos_q, pos_d;
  logic [tfs_pkg::IDX_W-1:0]  show_q, show_d;
  logic [tfs_pkg::TIME_W-1:0] timer_q, timer_d;
  logic                       fin_q, fin_d;

  logic                          jerr;
  logic [tfs_pkg::VALUE_W-1:0]   disp;
  logic [NextW-1:0]              next_full;
  logic [tfs_pkg::TIME_W:0]      sum_full;
  logic [tfs_pkg::TIME_W-1:0]    sum_sat;
  logic                          wr_ok;
  logic                          tgt_ok;
  tfs_pkg::table_wr_t            wr;
  tfs_pkg::table_rd_t            rd;
  tfs_pkg::entry_t               show_ent, next_ent, tgt_ent, zero_ent;

  tfs_step_table u_table (
    .clk_i        (clk_i),
    .wr_i         (wr),
    .rd_i         (rd),
    .show_entry_o (show_ent),
    .next_entry_o (next_ent),
    .tgt_entry_o  (tgt_ent),
    .zero_entry_o (zero_ent)
  );

  assign next_full = {1'b0, pos_q} + NextW'(1);
  assign sum_full  = {1'b0, timer_q} + {1'b0, item_i.elapsed};
  assign sum_sat   = sum_full[tfs_pkg::TIME_W] ? '1 : sum_full[tfs_pkg::TIME_W-1:0];
  assign wr_ok     = 32'(item_i.entry_index) < tfs_pkg::TABLE_DEPTH;
  assign tgt_ok    = {1'b0, next_ent.value} < (tfs_pkg::VALUE_W + 1)'(tfs_pkg::TABLE_DEPTH);

  always_comb begin
    rd.show_idx = show_q;
    rd.next_idx = next_full[tfs_pkg::IDX_W-1:0];
    rd.tgt_idx  = next_ent.value[tfs_pkg::IDX_W-1:0];
  end

  always_comb begin
    wr.en             = 1'b0;
    wr.idx            = tfs_pkg::IDX_W'(item_i.entry_index);
    wr.entry.kind     = item_i.entry_kind;
    wr.entry.value    = item_i.entry_value;
    wr.entry.duration = item_i.entry_duration;

    pos_d   = pos_q;
    show_d  = show_q;
    timer_d = timer_q;
    fin_d   = fin_q;
    jerr    = 1'b0;
    disp    = show_ent.value;

    unique case (item_i.cmd)
      tfs_pkg::CmdWrite: begin
        wr.en = fire_i && wr_ok;
        // a write to the shown slot is visible in this transfer's result
        if (wr_ok && (wr.idx == show_q)) begin
          disp = item_i.entry_value;
        end
      end
      tfs_pkg::CmdTick: begin
        if (!fin_q) begin
          timer_d = sum_sat;
          if (show_ent.duration <= sum_sat) begin
            timer_d = '0;
            if (next_full >= NextW'(tfs_pkg::TABLE_DEPTH)) begin
              // ran off the end of the table: hold on the last slot
              fin_d = 1'b1;
            end else if (next_ent.kind == tfs_pkg::KindFrame) begin
              pos_d  = rd.next_idx;
              show_d = rd.next_idx;
              disp   = next_ent.value;
            end else if (next_ent.kind == tfs_pkg::KindJump) begin
              if (tgt_ok && (tgt_ent.kind == tfs_pkg::KindFrame)) begin
                pos_d  = rd.tgt_idx;
                show_d = rd.tgt_idx;
                disp   = tgt_ent.value;
              end else begin
                pos_d  = '0;
                show_d = '0;
                fin_d  = 1'b0;
                jerr   = 1'b1;
                disp   = zero_ent.value;
              end
            end else begin
              // end entry, or the unused kind code: stop, keep last frame
              pos_d = rd.next_idx;
              fin_d = 1'b1;
            end
          end
        end
      end
      tfs_pkg::CmdRestart: begin
        pos_d   = '0;
        show_d  = '0;
        timer_d = '0;
        fin_d   = 1'b0;
        disp    = zero_ent.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      show_q  <= '0;
      timer_q <= '0;
      fin_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      show_q  <= show_d;
      timer_q <= timer_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    res_o.display_frame = disp;
    res_o.position      = tfs_pkg::SLOT_W'(pos_d);
    res_o.done_res      = fin_d;
    res_o.jump_error    = jerr;
  end

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.cmd == tfs_pkg::CmdRestart)
    |=> (pos_q == '0) && (show_q == '0) && (timer_q == '0) && !fin_q)
    else $error("restart did not clear the sequencer state");

  a_finished_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.cmd == tfs_pkg::CmdTick) && fin_q
    |=> $stable(pos_q) && $stable(show_q) && $stable(timer_q) && fin_q)
    else $error("tick changed state after the sequence finished");

  a_jump_error_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && jerr |=> (pos_q == '0) && (show_q == '0) && !fin_q)
    else $error("bad jump did not restart at entry zero");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(pos_q) && $stable(timer_q) && $stable(fin_q))
    else $error("sequencer state moved without a transfer");

endmodule

// ===== rtl/timed_frame_sequencer_unit.sv =====
// Timed frame sequencer: runs a 16-entry program of timed frame, jump and end
// steps. Every input transfer (write entry, time tick, restart) yields exactly
// one result with the shown frame, position, done flag and jump error. One
// item is taken per clock cycle unless out_ready_i holds the output back; the
// item is registered in the input register, the whole tick (saturating add,
// expiry compare, two chained table reads) resolves combinationally from it,
// and the result is registered in the output register, where it is offered
// until out_ready_i takes it. The output register lets a new item enter while
// a finished result still waits for out_ready_i.
module timed_frame_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tfs_pkg::CMD_W-1:0]     cmd_i,
  input  logic [tfs_pkg::SLOT_W-1:0]    entry_index_i,
  input  logic [tfs_pkg::KIND_W-1:0]    entry_kind_i,
  input  logic [tfs_pkg::VALUE_W-1:0]   entry_value_i,
  input  logic [tfs_pkg::TIME_W-1:0]    entry_duration_i,
  input  logic [tfs_pkg::TIME_W-1:0]    elapsed_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tfs_pkg::VALUE_W-1:0]   display_frame_o,
  output logic [tfs_pkg::SLOT_W-1:0]    position_o,
  output logic                          done_res_o,
  output logic                          jump_error_o
);

  logic               s1_valid_q;
  tfs_pkg::item_t     s1_item_q;
  logic               out_valid_q;
  tfs_pkg::result_t   out_res_q;
  tfs_pkg::result_t   res;
  logic               advance;
  logic               fire;
  logic               in_xfer;

  // result register free or draining this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.cmd            <= cmd_i;
      s1_item_q.entry_index    <= entry_index_i;
      s1_item_q.entry_kind     <= entry_kind_i;
      s1_item_q.entry_value    <= entry_value_i;
      s1_item_q.entry_duration <= entry_duration_i;
      s1_item_q.elapsed        <= elapsed_i;
    end
    if (fire) begin
      out_res_q <= res;
    end
  end

  tfs_seq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  assign out_valid_o     = out_valid_q;
  assign display_frame_o = out_res_q.display_frame;
  assign position_o      = out_res_q.position;
  assign done_res_o      = out_res_q.done_res;
  assign jump_error_o    = out_res_q.jump_error;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the timed frame sequencer unit
module testbench;

  localparam logic [tfs_pkg::CMD_W-1:0]  CmdNop       = 2'd3;
  localparam logic [tfs_pkg::KIND_W-1:0] KindUnused   = 2'd3;
  localparam int unsigned                CYCLE_LIMIT  = 200000;
  localparam int unsigned                DRAIN_CYCLES = 8;
  localparam int unsigned                PHASE_ITEMS  = 265;
  localparam int unsigned                HOLD_CYCLES  = 300;

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_ready_o;
  logic [tfs_pkg::CMD_W-1:0]    cmd_i            = tfs_pkg::CmdWrite;
  logic [tfs_pkg::SLOT_W-1:0]   entry_index_i    = '0;
  logic [tfs_pkg::KIND_W-1:0]   entry_kind_i     = tfs_pkg::KindFrame;
  logic [tfs_pkg::VALUE_W-1:0]  entry_value_i    = '0;
  logic [tfs_pkg::TIME_W-1:0]   entry_duration_i = '0;
  logic [tfs_pkg::TIME_W-1:0]   elapsed_i        = '0;
  logic                         out_valid_o;
  logic                         out_ready_i      = 1'b0;
  logic [tfs_pkg::VALUE_W-1:0]  display_frame_o;
  logic [tfs_pkg::SLOT_W-1:0]   position_o;
  logic                         done_res_o;
  logic                         jump_error_o;

  timed_frame_sequencer_unit i_dut (.*);

  always #4 clk_i = ~clk_i;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned items_sent     = 0;
  int unsigned errors         = 0;
  int unsigned cycles         = 0;
  bit          table_loaded   = 1'b0;

  tfs_pkg::result_t status_queue[$];

  // predicted sequencer state
  tfs_pkg::entry_t            prog_mem [tfs_pkg::TABLE_DEPTH];
  logic [tfs_pkg::IDX_W-1:0]  pos_q   = '0;
  logic [tfs_pkg::IDX_W-1:0]  show_q  = '0;
  logic [tfs_pkg::TIME_W-1:0] timer_q = '0;
  logic                       done_q  = 1'b0;

  function automatic void rewind();
    pos_q   = '0;
    show_q  = '0;
    timer_q = '0;
    done_q  = 1'b0;
  endfunction

  // move past the expired step, returns 1 on a bad jump
  function automatic logic step_forward();
    logic [tfs_pkg::IDX_W:0]     nxt;
    logic [tfs_pkg::VALUE_W-1:0] tgt;
    nxt = {1'b0, pos_q} + 1'b1;
    timer_q = '0;
    if (nxt >= tfs_pkg::TABLE_DEPTH) begin
      done_q = 1'b1;
      return 1'b0;
    end
    case (prog_mem[nxt[tfs_pkg::IDX_W-1:0]].kind)
      tfs_pkg::KindFrame: begin
        pos_q  = nxt[tfs_pkg::IDX_W-1:0];
        show_q = nxt[tfs_pkg::IDX_W-1:0];
      end
      tfs_pkg::KindJump: begin
        tgt = prog_mem[nxt[tfs_pkg::IDX_W-1:0]].value;
        if (tgt < tfs_pkg::TABLE_DEPTH &&
            prog_mem[tgt[tfs_pkg::IDX_W-1:0]].kind == tfs_pkg::KindFrame) begin
          pos_q  = tgt[tfs_pkg::IDX_W-1:0];
          show_q = tgt[tfs_pkg::IDX_W-1:0];
        end else begin
          rewind();
          return 1'b1;
        end
      end
      // end entry, kind three included
      default: begin
        pos_q  = nxt[tfs_pkg::IDX_W-1:0];
        done_q = 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic tfs_pkg::result_t predict_status(tfs_pkg::item_t it);
    tfs_pkg::result_t         r;
    logic [tfs_pkg::TIME_W:0] sum;
    logic                     jerr;
    jerr = 1'b0;
    case (it.cmd)
      tfs_pkg::CmdWrite: begin
        prog_mem[it.entry_index].kind     = it.entry_kind;
        prog_mem[it.entry_index].value    = it.entry_value;
        prog_mem[it.entry_index].duration = it.entry_duration;
      end
      tfs_pkg::CmdTick: begin
        if (!done_q) begin
          sum = {1'b0, timer_q} + {1'b0, it.elapsed};
          timer_q = sum[tfs_pkg::TIME_W] ? '1 : sum[tfs_pkg::TIME_W-1:0];
          if (prog_mem[show_q].duration <= timer_q) jerr = step_forward();
        end
      end
      tfs_pkg::CmdRestart: rewind();
      default: ;
    endcase
    r.display_frame = prog_mem[show_q].value;
    r.position      = tfs_pkg::SLOT_W'(pos_q);
    r.done_res      = done_q;
    r.jump_error    = jerr;
    return r;
  endfunction

  task automatic send_item(tfs_pkg::item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= it.cmd;
    entry_index_i    <= it.entry_index;
    entry_kind_i     <= it.entry_kind;
    entry_value_i    <= it.entry_value;
    entry_duration_i <= it.entry_duration;
    elapsed_i        <= it.elapsed;
    do @(posedge clk_i); while (!in_ready_o);
    status_queue.insert(status_queue.size(), predict_status(it));
    items_sent++;
  endtask

  // unused fields carry random bits
  function automatic tfs_pkg::item_t noise_item(logic [tfs_pkg::CMD_W-1:0] c);
    tfs_pkg::item_t it;
    it.cmd            = c;
    it.entry_index    = tfs_pkg::SLOT_W'($urandom);
    it.entry_kind     = tfs_pkg::KIND_W'($urandom);
    it.entry_value    = tfs_pkg::VALUE_W'($urandom);
    it.entry_duration = $urandom;
    it.elapsed        = $urandom;
    return it;
  endfunction

  task automatic write_step(logic [tfs_pkg::SLOT_W-1:0] idx,
                            logic [tfs_pkg::KIND_W-1:0] kind,
                            logic [tfs_pkg::VALUE_W-1:0] value,
                            logic [tfs_pkg::TIME_W-1:0] dur);
    tfs_pkg::item_t it;
    it = noise_item(tfs_pkg::CmdWrite);
    it.entry_index    = idx;
    it.entry_kind     = kind;
    it.entry_value    = value;
    it.entry_duration = dur;
    send_item(it);
  endtask

  task automatic tick(logic [tfs_pkg::TIME_W-1:0] el);
    tfs_pkg::item_t it;
    it = noise_item(tfs_pkg::CmdTick);
    it.elapsed = el;
    send_item(it);
  endtask

  task automatic send_cmd(logic [tfs_pkg::CMD_W-1:0] c);
    send_item(noise_item(c));
  endtask

  function automatic logic [tfs_pkg::TIME_W-1:0] short_span();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return $urandom;
    return $urandom_range(3 << 16);
  endfunction

  task automatic write_random_step(logic [tfs_pkg::SLOT_W-1:0] idx);
    int unsigned                 r;
    logic [tfs_pkg::VALUE_W-1:0] tgt;
    r = $urandom_range(99);
    if (r < 65) begin
      write_step(idx, tfs_pkg::KindFrame, tfs_pkg::VALUE_W'($urandom), short_span());
    end else if (r < 82) begin
      if ($urandom_range(99) < 85) begin
        tgt = tfs_pkg::VALUE_W'($urandom_range(tfs_pkg::TABLE_DEPTH-1));
      end else begin
        tgt = tfs_pkg::VALUE_W'($urandom);
      end
      write_step(idx, tfs_pkg::KindJump, tgt, $urandom);
    end else if (r < 94) begin
      write_step(idx, tfs_pkg::KindEnd, tfs_pkg::VALUE_W'($urandom), $urandom);
    end else begin
      write_step(idx, KindUnused, tfs_pkg::VALUE_W'($urandom), short_span());
    end
  endtask

  task automatic run_programs(int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned i;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if (!table_loaded) begin
        for (i = 0; i < tfs_pkg::TABLE_DEPTH; i++) write_random_step(tfs_pkg::SLOT_W'(i));
        table_loaded = 1'b1;
      end else begin
        repeat ($urandom_range(3, 8))
          write_random_step(tfs_pkg::SLOT_W'($urandom_range(tfs_pkg::TABLE_DEPTH-1)));
      end
      send_cmd(tfs_pkg::CmdRestart);
      repeat ($urandom_range(15, 60)) begin
        r = $urandom_range(99);
        if (r < 82) tick(short_span());
        else if (r < 89) send_cmd(tfs_pkg::CmdRestart);
        else if (r < 93) send_cmd(CmdNop);
        else write_random_step(tfs_pkg::SLOT_W'($urandom_range(tfs_pkg::TABLE_DEPTH-1)));
      end
    end
  endtask

  // zero duration, saturation, good and bad jumps, kind three as end, frozen tick
  task automatic test_directed_walk();
    write_step(4'd0, tfs_pkg::KindFrame, 16'hFFFF, 32'h0000_0000);
    write_step(4'd1, tfs_pkg::KindFrame, 16'h0000, 32'hFFFF_FFFF);
    write_step(4'd2, tfs_pkg::KindJump, 16'd4, 32'h5555_AAAA);
    write_step(4'd4, tfs_pkg::KindFrame, 16'h1234, 32'd1);
    write_step(4'd5, tfs_pkg::KindJump, 16'hFFFF, 32'hAAAA_5555);
    write_step(4'd6, tfs_pkg::KindFrame, 16'hA5A5, 32'd0);
    write_step(4'd7, KindUnused, 16'h5A5A, 32'd0);
    write_step(4'd15, tfs_pkg::KindFrame, 16'h7777, 32'd0);
    tick(32'h0000_0000);
    tick(32'h8000_0000);
    tick(32'hFFFF_FFFF);
    tick(32'd1);
    // jump onto another jump entry
    write_step(4'd5, tfs_pkg::KindJump, 16'd2, 32'd0);
    tick(32'd0);
    tick(32'hFFFF_FFFF);
    tick(32'd1);
    write_step(4'd5, tfs_pkg::KindFrame, 16'h0F0F, 32'd2);
    send_cmd(CmdNop);
    tick(32'd0);
    tick(32'hFFFF_FFFF);
    tick(32'd1);
    tick(32'd1);
    tick(32'd1);
    tick(32'd0);
    tick(32'hFFFF_FFFF);
    send_cmd(tfs_pkg::CmdRestart);
  endtask

  // running off the last entry, a non-frame entry zero, a plain end entry
  task automatic test_sequence_edges();
    write_step(4'd5, tfs_pkg::KindJump, 16'd15, 32'd0);
    send_cmd(tfs_pkg::CmdRestart);
    tick(32'd0);
    tick(32'hFFFF_FFFF);
    tick(32'd1);
    tick(32'd0);
    tick(32'd7);
    write_step(4'd7, tfs_pkg::KindEnd, 16'h0000, 32'd0);
    write_step(4'd0, tfs_pkg::KindEnd, 16'hBEEF, 32'd0);
    send_cmd(tfs_pkg::CmdRestart);
    tick(32'd0);
    write_step(4'd5, tfs_pkg::KindFrame, 16'hC3C3, 32'd0);
    tick(32'hFFFF_FFFF);
    tick(32'd1);
    tick(32'd0);
    tick(32'd0);
    send_cmd(tfs_pkg::CmdRestart);
  endtask

  task automatic test_random_phase(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    run_programs(PHASE_ITEMS);
  endtask

  // receiver holds off while the sender keeps offering transfers
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (40) tick(short_span());
  endtask

  task automatic check_field(string name, logic [tfs_pkg::VALUE_W-1:0] want,
                             logic [tfs_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    tfs_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none got frame %h position %0d",
                 $time, display_frame_o, position_o);
        errors++;
      end else begin
        want = status_queue.pop_front();
        check_field("display_frame", want.display_frame, display_frame_o);
        check_field("position", tfs_pkg::VALUE_W'(want.position),
                    tfs_pkg::VALUE_W'(position_o));
        check_field("done_res", tfs_pkg::VALUE_W'(want.done_res),
                    tfs_pkg::VALUE_W'(done_res_o));
        check_field("jump_error", tfs_pkg::VALUE_W'(want.jump_error),
                    tfs_pkg::VALUE_W'(jump_error_o));
      end
    end
  end

  // receiver: random stalls, or a long hold counted here in cycles
  always @(posedge clk_i) begin : ready_driver
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_walk();
    test_sequence_edges();
    test_random_phase(0, 0);
    test_backpressure();
    test_random_phase(75, 0);
    test_random_phase(0, 75);
    test_random_phase(16, 16);
    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    while (status_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tfs_pkg.sv
rtl/tfs_step_table.sv
rtl/tfs_seq_ctrl.sv
rtl/timed_frame_sequencer_unit.sv
tb/testbench.sv
